FILE: hw/rtl/sacl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sacl_pkg;

    localparam int IN_ADDR_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int WAY_OUT_W  = 2;
    localparam int SET_OUT_W  = 7;
    localparam int OUT_DATA_W = 16;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic                 evicted;
        logic                 evicted_dirty;
        logic [SET_OUT_W-1:0] set_number;
    } t_res;

endpackage
`default_nettype wire

FILE: hw/rtl/sacl_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sacl_front #(
    parameter int ADDR_BITS   = 32,
    parameter int OFFSET_BITS = 6,
    parameter int SET_BITS    = 7
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_valid,
    output logic                                         o_ready,
    input  wire  [sacl_pkg::IN_ADDR_W-1:0]               i_address,
    input  wire                                          i_opcode,
    output logic                                         o_valid,
    input  wire                                          i_ready,
    output logic [ADDR_BITS-OFFSET_BITS-SET_BITS-1:0]    o_tag,
    output logic [SET_BITS-1:0]                          o_set,
    output logic                                         o_wr
);

    localparam int TAG_W = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int EXT_W = (ADDR_BITS > sacl_pkg::IN_ADDR_W) ? ADDR_BITS : sacl_pkg::IN_ADDR_W;

    logic [EXT_W-1:0]     addr_ext;
    logic [ADDR_BITS-1:0] addr_m;
    logic                 r_valid;
    logic [TAG_W-1:0]     r_tag;
    logic [SET_BITS-1:0]  r_set;
    logic                 r_wr;

    assign addr_ext = EXT_W'(i_address);
    assign addr_m   = addr_ext[ADDR_BITS-1:0];
    assign o_ready  = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_tag <= addr_m[ADDR_BITS-1:OFFSET_BITS+SET_BITS];
            r_set <= addr_m[OFFSET_BITS+SET_BITS-1:OFFSET_BITS];
            r_wr  <= (i_opcode == sacl_pkg::OP_WRITE);
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_set   = r_set;
    assign o_wr    = r_wr;

endmodule
`default_nettype wire

FILE: hw/rtl/sacl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sacl_queue #(
    parameter int WIDTH = 20
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/sacl_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sacl_back #(
    parameter int TAG_W    = 19,
    parameter int SET_BITS = 7,
    parameter int WAYS     = 4
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_q_valid,
    output logic                    o_q_pop,
    input  wire  [TAG_W+SET_BITS:0] i_q_data,
    output logic                    o_valid,
    input  wire                     i_ready,
    output sacl_pkg::t_res          o_res
);

    localparam int SETS  = 1 << SET_BITS;
    localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * (2 + AGE_W + TAG_W);
    localparam int A_LO  = 2 * WAYS;
    localparam int T_LO  = 2 * WAYS + WAYS * AGE_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic [ROW_W-1:0]    r_mem [SETS];
    logic [SETS-1:0]     r_row_live;
    logic                r_state;
    logic [ROW_W-1:0]    r_row;
    logic                r_live;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_BITS-1:0] r_set;
    logic                r_wr;
    logic                r_out_valid;
    sacl_pkg::t_res      r_out;

    logic [SET_BITS-1:0] q_set;
    logic                finish;
    logic [ROW_W-1:0]    n_row;
    sacl_pkg::t_res      n_res;

    assign q_set   = i_q_data[SET_BITS:1];
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign finish  = (r_state == S_CALC) && (!r_out_valid || i_ready);

    always_comb begin
        logic [WAYS-1:0]             v;
        logic [WAYS-1:0]             d;
        logic [WAYS-1:0][AGE_W-1:0]  a;
        logic [WAYS-1:0][TAG_W-1:0]  t;
        logic [WAYS-1:0]             nv;
        logic [WAYS-1:0]             nd;
        logic [WAYS-1:0][AGE_W-1:0]  na;
        logic [WAYS-1:0][TAG_W-1:0]  nt;
        logic [AGE_W-1:0]            way;
        logic [AGE_W-1:0]            victim;
        logic [AGE_W-1:0]            best;
        logic                        hit;
        logic                        found;
        logic                        ev;
        logic                        evd;
        logic [31:0]                 way_ext;
        logic [31:0]                 set_ext;
        for (int w = 0; w < WAYS; w++) begin
            v[w] = r_live && r_row[w];
            d[w] = r_live && r_row[WAYS+w];
            a[w] = r_live ? r_row[A_LO+w*AGE_W +: AGE_W] : '0;
            t[w] = r_row[T_LO+w*TAG_W +: TAG_W];
        end
        nv = v;
        nd = d;
        na = a;
        nt = t;
        hit = 1'b0;
        way = '0;
        ev = 1'b0;
        evd = 1'b0;
        victim = '0;
        best = '0;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && v[w] && (t[w] == r_tag)) begin
                hit = 1'b1;
                way = AGE_W'(w);
            end
        end
        if (hit) begin
            if (r_wr) begin
                nd[way] = 1'b1;
            end else begin
                na[way] = '0;
                for (int w = 0; w < WAYS; w++) begin
                    if (v[w] && (AGE_W'(w) != way)) begin
                        na[w] = (a[w] == AGE_W'(WAYS - 1)) ? '0 : a[w] + AGE_W'(1);
                    end
                end
            end
        end else begin
            if (&v) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (v[w] && (a[w] > best)) begin
                        best = a[w];
                        victim = AGE_W'(w);
                    end
                end
                ev = 1'b1;
                evd = d[victim];
                nv[victim] = 1'b0;
                na[victim] = '0;
            end
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !nv[w]) begin
                    found = 1'b1;
                    way = AGE_W'(w);
                end
            end
            for (int w = 0; w < WAYS; w++) begin
                if (nv[w] && (AGE_W'(w) != way)) begin
                    na[w] = (na[w] == AGE_W'(WAYS - 1)) ? '0 : na[w] + AGE_W'(1);
                end
            end
            nv[way] = 1'b1;
            nd[way] = 1'b0;
            na[way] = '0;
            nt[way] = r_tag;
        end
        for (int w = 0; w < WAYS; w++) begin
            n_row[w] = nv[w];
            n_row[WAYS+w] = nd[w];
            n_row[A_LO+w*AGE_W +: AGE_W] = na[w];
            n_row[T_LO+w*TAG_W +: TAG_W] = nt[w];
        end
        way_ext = 32'(way);
        set_ext = 32'(r_set);
        n_res.hit = hit;
        n_res.way_used = way_ext[sacl_pkg::WAY_OUT_W-1:0];
        n_res.evicted = ev;
        n_res.evicted_dirty = evd;
        n_res.set_number = set_ext[sacl_pkg::SET_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_row_live  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_valid       <= 1'b1;
                r_row_live[r_set] <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_row  <= r_mem[q_set];
            r_live <= r_row_live[q_set];
            r_wr   <= i_q_data[0];
            r_set  <= q_set;
            r_tag  <= i_q_data[TAG_W+SET_BITS:SET_BITS+1];
        end
        if (finish) begin
            r_mem[r_set] <= n_row;
            r_out        <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_cache_tag_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// Tag store of a set-associative cache with age-based replacement.
// s_axis: one access per item; tdata is the byte address, tuser the opcode
// (0 read, 1 write).
// m_axis: one result per access, in order; tdata carries hit, way used,
// eviction flag, dirty mark of the evicted line and set index.
// A front stage splits the address into set and tag and hands the item to a
// two-entry queue; the back end reads the set's row from the tag memory,
// updates it and writes it back.
// An accepted item passes the front stage register, a queue entry, the back
// end's row register and the result register before m_axis_tvalid. The back
// end takes no new item until the last one's tag row is written back.
// Reset empties the cache at once (one live flag per set); no sweep.
// A stalled m_axis holds its result; the back end, queue and front stage
// still take up to four further items before s_axis_tready falls.
module set_assoc_cache_tag_lookup #(
    parameter int ADDR_BITS   = 32,
    parameter int OFFSET_BITS = 6,
    parameter int SET_BITS    = 7,
    parameter int WAYS        = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [sacl_pkg::IN_ADDR_W-1:0]        s_axis_tdata,  // address
    input  wire  [sacl_pkg::IN_USER_W-1:0]        s_axis_tuser,  // opcode
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // hit, way_used[2:1], evicted, evicted_dirty, set_number[11:5], zero pad
    output logic [sacl_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int TAG_W = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int REQ_W = TAG_W + SET_BITS + 1;
    localparam int PAD_W = sacl_pkg::OUT_DATA_W - 3 - sacl_pkg::WAY_OUT_W
                           - sacl_pkg::SET_OUT_W;

    logic                          f_valid;
    logic                          f_ready;
    logic [TAG_W-1:0]              f_tag_w;
    logic [SET_BITS-1:0]           f_set;
    logic                          f_wr;
    logic                          q_valid;
    logic                          q_pop;
    logic [REQ_W-1:0]              q_data;
    sacl_pkg::t_res                res;

    sacl_front #(
        .ADDR_BITS   (ADDR_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .SET_BITS    (SET_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_address (s_axis_tdata),
        .i_opcode  (s_axis_tuser[0]),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_tag     (f_tag_w),
        .o_set     (f_set),
        .o_wr      (f_wr)
    );

    sacl_queue #(
        .WIDTH (REQ_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_tag_w, f_set, f_wr}),
        .o_ready (f_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    sacl_back #(
        .TAG_W    (TAG_W),
        .SET_BITS (SET_BITS),
        .WAYS     (WAYS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_data  (q_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, res.set_number, res.evicted_dirty, res.evicted,
                           res.way_used, res.hit};

endmodule
`default_nettype wire
